FILE: design/pcps_pkg.sv
// ----------------------------------------------------------------------------
// pcps_pkg: shared types and constants
// Register indexes, fixed field widths, controller states and the control
// structs passed between the controller, the vertex cells and the edge unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcps_pkg;

   localparam int COUNT_W     = 5;   // vertex_count register
   localparam int TOL_W       = 20;  // collinear_tolerance register
   localparam int INDEX_W     = 4;   // vertex_index field
   localparam int CSR_INDEX_W = 2;
   localparam int MIN_EDGES   = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FLOOR_Z      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CEILING_Z    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE    = 2'd3;

   localparam logic MODE_VERTEX = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic start;
      logic edge_valid;
   } eval_ctrl_type;

   typedef struct packed {
      logic busy;
      logic reject;
   } eval_status_type;

endpackage

FILE: design/pcps_req_if.sv
// ----------------------------------------------------------------------------
// pcps_req_if: request channel
// Valid/ready channel carrying vertex writes and point queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcps_req_if #(
   parameter int COORD_WIDTH = 24
);
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic [pcps_pkg::INDEX_W-1:0]        vertex_index;
   logic signed [COORD_WIDTH-1:0]       coord_x;
   logic signed [COORD_WIDTH-1:0]       coord_y;
   logic signed [COORD_WIDTH-1:0]       coord_z;

   modport source (
      output valid, mode, vertex_index, coord_x, coord_y, coord_z,
      input  ready
   );

   modport sink (
      input  valid, mode, vertex_index, coord_x, coord_y, coord_z,
      output ready
   );
endinterface

FILE: design/pcps_rsp_if.sv
// ----------------------------------------------------------------------------
// pcps_rsp_if: response channel
// Valid/ready channel carrying the inside flag of one query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcps_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (
      output valid, inside_res,
      input  ready
   );

   modport sink (
      input  valid, inside_res,
      output ready
   );
endinterface

FILE: design/point_in_convex_polygon_slab.sv
// ----------------------------------------------------------------------------
// point_in_convex_polygon_slab: point-in-prism test over a convex polygon
// A new request is taken only while idle: a query occupies the block until its
// result is loaded, which waits while the previous response is still held;
// vertex writes are also taken only while idle. Each query runs one full
// rotation of the vertex ring, one vertex per cycle into a single pipelined
// edge unit, plus its drain.
// Reset clears the registers and controller; vertex slots hold garbage until
// written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_convex_polygon_slab #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_WIDTH  = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [pcps_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [((COORD_WIDTH > pcps_pkg::TOL_W) ?
                  COORD_WIDTH : pcps_pkg::TOL_W)-1:0] csr_wdata,
   pcps_req_if.sink                               req_chan,
   pcps_rsp_if.source                             rsp_chan
);
   import pcps_pkg::*;

   localparam int STEP_W = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W  = (STEP_W > COUNT_W) ? STEP_W : COUNT_W;

   // configuration
   logic [COUNT_W-1:0]            vertex_count_ff, vertex_count_in;
   logic signed [COORD_WIDTH-1:0] floor_z_ff, floor_z_in;
   logic signed [COORD_WIDTH-1:0] ceiling_z_ff, ceiling_z_in;
   logic [TOL_W-1:0]              tolerance_ff, tolerance_in;

   // controller
   state_type                     state_ff, state_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_inside_ff, rsp_inside_in;
   logic                          z_ok_ff, z_ok_in;
   logic signed [COORD_WIDTH-1:0] point_x_ff, point_x_in;
   logic signed [COORD_WIDTH-1:0] point_y_ff, point_y_in;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_x_in;
   logic signed [COORD_WIDTH-1:0] prev_y_ff, prev_y_in;
   logic signed [COORD_WIDTH-1:0] first_x_ff, first_x_in;
   logic signed [COORD_WIDTH-1:0] first_y_ff, first_y_in;

   logic                          req_ready;
   logic                          req_xfer;
   logic                          vertex_write;
   logic                          query_start;
   logic                          ring_shift;
   logic                          edge_valid;
   logic                          rsp_load;
   logic                          last_step;
   logic [CMP_W-1:0]              count_wide;
   logic [STEP_W-1:0]             n_eff;
   logic                          enough_edges;
   logic signed [COORD_WIDTH-1:0] cur_x;
   logic signed [COORD_WIDTH-1:0] cur_y;

   logic signed [COORD_WIDTH-1:0] cell_x [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] cell_y [MAX_VERTICES];

   eval_ctrl_type                 eval_ctrl;
   eval_status_type               eval_status;

   // ---------------- configuration port ----------------
   always_comb begin
      vertex_count_in = vertex_count_ff;
      floor_z_in      = floor_z_ff;
      ceiling_z_in    = ceiling_z_ff;
      tolerance_in    = tolerance_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_VERTEX_COUNT: vertex_count_in = csr_wdata[COUNT_W-1:0];
            REG_FLOOR_Z:      floor_z_in      = csr_wdata[COORD_WIDTH-1:0];
            REG_CEILING_Z:    ceiling_z_in    = csr_wdata[COORD_WIDTH-1:0];
            REG_TOLERANCE:    tolerance_in    = csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // counts above the ring size saturate
   always_comb begin
      count_wide   = CMP_W'(vertex_count_ff);
      n_eff        = (count_wide > CMP_W'(MAX_VERTICES)) ? STEP_W'(MAX_VERTICES)
                                                         : STEP_W'(count_wide);
      enough_edges = (n_eff >= STEP_W'(MIN_EDGES));
   end

   // ---------------- controller ----------------
   assign req_xfer     = req_chan.valid & req_ready;
   assign vertex_write = req_xfer & (req_chan.mode == MODE_VERTEX);
   assign query_start  = req_xfer & (req_chan.mode == MODE_QUERY);
   assign last_step    = (step_ff == STEP_W'(MAX_VERTICES));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!eval_status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ring_shift = 1'b0;
      edge_valid = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_RUN: begin
            ring_shift = !last_step;
            edge_valid = (step_ff != '0) && (step_ff <= n_eff);
         end
         ST_DRAIN: ;
         ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: ;
      endcase
   end

   // closing edge wraps back to vertex 0
   always_comb begin
      cur_x = (step_ff == n_eff) ? first_x_ff : cell_x[0];
      cur_y = (step_ff == n_eff) ? first_y_ff : cell_y[0];
   end

   always_comb begin
      step_in    = step_ff;
      z_ok_in    = z_ok_ff;
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      if (query_start) begin
         step_in    = '0;
         z_ok_in    = !((req_chan.coord_z < floor_z_ff) ||
                        (req_chan.coord_z > ceiling_z_ff));
         point_x_in = req_chan.coord_x;
         point_y_in = req_chan.coord_y;
      end
      if (state_ff == ST_RUN) begin
         step_in   = last_step ? step_ff : step_ff + STEP_W'(1);
         prev_x_in = cur_x;
         prev_y_in = cur_y;
         if (step_ff == '0) begin
            first_x_in = cell_x[0];
            first_y_in = cell_y[0];
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_inside_in = rsp_inside_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_inside_in = z_ok_ff && enough_edges && !eval_status.reject;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         vertex_count_ff <= '0;
         floor_z_ff      <= '0;
         ceiling_z_ff    <= '0;
         tolerance_ff    <= '0;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
         vertex_count_ff <= vertex_count_in;
         floor_z_ff      <= floor_z_in;
         ceiling_z_ff    <= ceiling_z_in;
         tolerance_ff    <= tolerance_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= rsp_inside_in;
      z_ok_ff       <= z_ok_in;
      point_x_ff    <= point_x_in;
      point_y_ff    <= point_y_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      first_x_ff    <= first_x_in;
      first_y_ff    <= first_y_in;
   end

   // ---------------- vertex ring ----------------
   // cell 0 is the head; a full rotation returns every vertex to its slot
   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      cell_ctrl_type cell_ctrl;

      assign cell_ctrl.load  = vertex_write && (int'(req_chan.vertex_index) == i);
      assign cell_ctrl.shift = ring_shift;

      pcps_vertex_cell #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .load_x   (req_chan.coord_x),
         .load_y   (req_chan.coord_y),
         .next_x   (cell_x[(i + 1) % MAX_VERTICES]),
         .next_y   (cell_y[(i + 1) % MAX_VERTICES]),
         .vertex_x (cell_x[i]),
         .vertex_y (cell_y[i])
      );
   end

   // ---------------- edge unit ----------------
   assign eval_ctrl.start      = query_start;
   assign eval_ctrl.edge_valid = edge_valid;

   pcps_edge_eval #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_edge_eval (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (eval_ctrl),
      .prev_x    (prev_x_ff),
      .prev_y    (prev_y_ff),
      .cur_x     (cur_x),
      .cur_y     (cur_y),
      .point_x   (point_x_ff),
      .point_y   (point_y_ff),
      .tolerance (tolerance_ff),
      .status    (eval_status)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.inside_res = rsp_inside_ff;

endmodule

FILE: design/pcps_vertex_cell.sv
// ----------------------------------------------------------------------------
// pcps_vertex_cell: one polygon vertex slot
// Holds one vertex; loads from the request channel or takes its neighbor's
// vertex when the ring rotates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcps_vertex_cell #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  pcps_pkg::cell_ctrl_type       ctrl,
   input  logic signed [COORD_WIDTH-1:0] load_x,
   input  logic signed [COORD_WIDTH-1:0] load_y,
   input  logic signed [COORD_WIDTH-1:0] next_x,
   input  logic signed [COORD_WIDTH-1:0] next_y,
   output logic signed [COORD_WIDTH-1:0] vertex_x,
   output logic signed [COORD_WIDTH-1:0] vertex_y
);
   import pcps_pkg::*;

   logic signed [COORD_WIDTH-1:0] x_ff, x_in;
   logic signed [COORD_WIDTH-1:0] y_ff, y_in;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (ctrl.load) begin
         x_in = load_x;
         y_in = load_y;
      end else if (ctrl.shift) begin
         x_in = next_x;
         y_in = next_y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign vertex_x = x_ff;
   assign vertex_y = y_ff;

endmodule

FILE: design/pcps_edge_eval.sv
// ----------------------------------------------------------------------------
// pcps_edge_eval: edge cross product and sign tracker
// Four-stage pipeline: differences, products, cross product, then the
// tolerance check and sign-consistency tracking. One edge per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcps_edge_eval #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcps_pkg::eval_ctrl_type       ctrl,
   input  logic signed [COORD_WIDTH-1:0] prev_x,
   input  logic signed [COORD_WIDTH-1:0] prev_y,
   input  logic signed [COORD_WIDTH-1:0] cur_x,
   input  logic signed [COORD_WIDTH-1:0] cur_y,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic [pcps_pkg::TOL_W-1:0]    tolerance,
   output pcps_pkg::eval_status_type     status
);
   import pcps_pkg::*;

   localparam int D_W = COORD_WIDTH + 1;
   localparam int P_W = 2 * D_W;
   localparam int C_W = P_W + 1;

   logic                  valid1_ff, valid1_in;
   logic                  valid2_ff, valid2_in;
   logic                  valid3_ff, valid3_in;
   logic signed [D_W-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic signed [D_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [P_W-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic signed [C_W-1:0] cross_ff, cross_in;
   logic                  have_sign_ff, have_sign_in;
   logic                  last_neg_ff, last_neg_in;
   logic                  reject_ff, reject_in;

   logic signed [C_W-1:0] tol_pos;
   logic signed [C_W-1:0] tol_neg;
   logic                  keep;
   logic                  neg;

   always_comb begin
      ex_in     = D_W'(cur_x) - D_W'(prev_x);
      ey_in     = D_W'(cur_y) - D_W'(prev_y);
      tx_in     = D_W'(point_x) - D_W'(prev_x);
      ty_in     = D_W'(point_y) - D_W'(prev_y);
      prod_a_in = P_W'(ex_ff) * P_W'(ty_ff);
      prod_b_in = P_W'(ey_ff) * P_W'(tx_ff);
      cross_in  = C_W'(prod_a_ff) - C_W'(prod_b_ff);
      valid1_in = ctrl.edge_valid;
      valid2_in = valid1_ff;
      valid3_in = valid2_ff;
   end

   // |cross| > tol, checked on both sides without negating the cross product
   always_comb begin
      tol_pos = signed'(C_W'(tolerance));
      tol_neg = -tol_pos;
      neg     = cross_ff[C_W-1];
      keep    = (cross_ff > tol_pos) || (cross_ff < tol_neg);
   end

   always_comb begin
      have_sign_in = have_sign_ff;
      last_neg_in  = last_neg_ff;
      reject_in    = reject_ff;
      if (ctrl.start) begin
         have_sign_in = 1'b0;
         last_neg_in  = 1'b0;
         reject_in    = 1'b0;
      end else if (valid3_ff && keep) begin
         if (have_sign_ff && (neg != last_neg_ff)) begin
            reject_in = 1'b1;
         end
         have_sign_in = 1'b1;
         last_neg_in  = neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         have_sign_ff <= 1'b0;
         last_neg_ff  <= 1'b0;
         reject_ff    <= 1'b0;
      end else begin
         valid1_ff    <= valid1_in;
         valid2_ff    <= valid2_in;
         valid3_ff    <= valid3_in;
         have_sign_ff <= have_sign_in;
         last_neg_ff  <= last_neg_in;
         reject_ff    <= reject_in;
      end
   end

   always_ff @(posedge clock) begin
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      cross_ff  <= cross_in;
   end

   assign status.busy   = valid1_ff | valid2_ff | valid3_ff;
   assign status.reject = reject_ff;

endmodule
